// ===== hdl/spectrum_bar_level_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// spectrum bar level tracker assertion macros
// shared property wrappers for the tracker modules
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BAR_LEVEL_TRACKER_DEFINES_SVH
`define SPECTRUM_BAR_LEVEL_TRACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SBLT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SBLT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `SBLT_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`else

`define SBLT_ASSERT(label, clk, rst_n, prop, msg)

`define SBLT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/sblt_pkg.sv =====
// ----------------------------------------------------------------------------
// sblt_pkg
// shared types, widths and constants of the spectrum bar level tracker
// ----------------------------------------------------------------------------
package sblt_pkg;

    localparam int BAR_COUNT_DEF = 36;
    localparam int BAR_W         = 6;
    localparam int MAG_W         = 32;
    localparam int LVL_W         = 16;
    localparam int AVG_W         = 24;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DAT_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FALL_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DECAY      = 2'd2;

    localparam logic [15:0] SMOOTH_GAIN_RST    = 16'd21627;
    localparam logic [15:0] PEAK_FALL_GAIN_RST = 16'd8520;
    localparam logic [15:0] MAX_DECAY_RST      = 16'd65143;

    localparam logic [20:0] NORM_C24    = 21'd1553983;
    localparam logic [15:0] PEAK_JUMP   = 16'd524;
    localparam logic [15:0] PEAK_HOLD   = 16'd786;
    localparam logic [15:0] SPEED_BASE  = 16'd6554;
    localparam logic [15:0] SPEED_SLOPE = 16'd4260;
    localparam logic [15:0] AVG_NEW     = 16'd26214;
    localparam logic [15:0] AVG_OLD     = 16'd39322;
    localparam logic [23:0] RATIO_MAX   = 24'hFFFFFF;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [LVL_W-1:0] target;
        logic [LVL_W-1:0] peak;
        logic [LVL_W-1:0] speed;
        logic [MAG_W-1:0] rmax;
        logic [AVG_W-1:0] avg;
    } t_row;

    localparam t_row ROW_RESET = '{
        level:  16'd0,
        target: 16'd0,
        peak:   16'd0,
        speed:  SPEED_BASE,
        rmax:   32'd1,
        avg:    24'd0
    };

    typedef struct packed {
        logic             cmd;
        logic [BAR_W-1:0] bar;
        logic [MAG_W-1:0] mag;
        logic             in_range;
    } t_item;

endpackage

// ===== hdl/sblt_if.sv =====
// ----------------------------------------------------------------------------
// sblt channel interfaces
// input item, result item and register write channels
// ----------------------------------------------------------------------------
interface sblt_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [sblt_pkg::BAR_W-1:0]  bar;
    logic [sblt_pkg::MAG_W-1:0]  band_magnitude;

    modport source (output valid, cmd, bar, band_magnitude, input ready);
    modport sink   (input valid, cmd, bar, band_magnitude, output ready);
endinterface

interface sblt_out_if;
    logic                        valid;
    logic                        ready;
    logic [sblt_pkg::BAR_W-1:0]  bar_out;
    logic [sblt_pkg::LVL_W-1:0]  level;
    logic [sblt_pkg::LVL_W-1:0]  peak;
    logic [sblt_pkg::LVL_W-1:0]  target;

    modport source (output valid, bar_out, level, peak, target, input ready);
    modport sink   (input valid, bar_out, level, peak, target, output ready);
endinterface

interface sblt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sblt_pkg::CFG_IDX_W-1:0]  index;
    logic [sblt_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/spectrum_bar_level_tracker.sv =====
// ----------------------------------------------------------------------------
// spectrum_bar_level_tracker
// per-bar level, target and peak tracker for a spectrum display
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  i_in     in   valid/ready   cmd, bar, band_magnitude
//  o_out    out  valid/ready   bar_out, level, peak, target
//  i_cfg    in   valid/ready   index, data (ready always high)
//
//  an update runs at most 24 divider steps and 16 log squarings, and two
//  20-step square roots, on one shared multiplier and sequencer
//  a tick loads the row and steps level and peak; an out-of-range bar goes straight to writeback
//  a two-entry queue takes input transfers while the sequencer works
//  the sequencer stalls in writeback until the result register is free
//  synchronous reset; per-bar state is reset through valid bits, no clear pass
// ----------------------------------------------------------------------------
module spectrum_bar_level_tracker #(
    parameter int BAR_COUNT = sblt_pkg::BAR_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sblt_in_if.sink     i_in,
    sblt_out_if.source  o_out,
    sblt_cfg_if.sink    i_cfg
);

    sblt_pkg::t_item q_item;
    logic            q_valid;
    logic            q_pop;

    sblt_front #(
        .BAR_COUNT (BAR_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (q_item),
        .o_item_valid (q_valid),
        .i_pop        (q_pop)
    );

    sblt_back #(
        .BAR_COUNT (BAR_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_item_valid (q_valid),
        .o_pop        (q_pop),
        .i_cfg        (i_cfg),
        .o_out        (o_out)
    );

endmodule

// ===== hdl/sblt_ram.sv =====
// ----------------------------------------------------------------------------
// sblt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sblt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                    i_wr_data,
    input  logic                                i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                    o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== hdl/sblt_front.sv =====
// ----------------------------------------------------------------------------
// sblt_front
// takes input transfers, checks the bar range and queues them for the back end
// ----------------------------------------------------------------------------
`include "spectrum_bar_level_tracker_defines.svh"

module sblt_front #(
    parameter int BAR_COUNT = sblt_pkg::BAR_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sblt_in_if.sink           i_in,
    output sblt_pkg::t_item   o_item,
    output logic              o_item_valid,
    input  logic              i_pop
);

    sblt_pkg::t_item r_slot [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            push;
    sblt_pkg::t_item new_item;

    assign i_in.ready   = (r_count != 2'd2);
    assign push         = i_in.valid && i_in.ready;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_slot[r_rd_ptr];

    always_comb begin
        new_item.cmd      = i_in.cmd;
        new_item.bar      = i_in.bar;
        new_item.mag      = i_in.band_magnitude;
        new_item.in_range = ({1'b0, i_in.bar} < (sblt_pkg::BAR_W+1)'(BAR_COUNT));
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= new_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `SBLT_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != 2'd0, "pop from empty queue")
    `SBLT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= 2'd2, "queue count overflow")
    `SBLT_ASSERT(a_count_push, i_clk, i_rst_n, (push && !i_pop) |=> r_count == $past(r_count) + 2'd1, "queue count lost a push")

endmodule

// ===== hdl/sblt_back.sv =====
// ----------------------------------------------------------------------------
// sblt_back
// per-bar sequencer: divide, average, log, power, peak and tick arithmetic
// ----------------------------------------------------------------------------
`include "spectrum_bar_level_tracker_defines.svh"

module sblt_back #(
    parameter int BAR_COUNT = sblt_pkg::BAR_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sblt_pkg::t_item   i_item,
    input  logic              i_item_valid,
    output logic              o_pop,
    sblt_cfg_if.sink          i_cfg,
    sblt_out_if.source        o_out
);

    localparam int AW = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;
    localparam int RW = $bits(sblt_pkg::t_row);

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_DIV, S_AVG1, S_AVG2, S_LOGN, S_LOG, S_NMUL,
        S_SQRT, S_PMUL, S_TMUL, S_TGT, S_MAX, S_TMULT, S_TPK, S_WB
    } t_state;

    t_state              r_state;
    logic [4:0]          r_cnt;
    logic                r_cmd;
    logic [5:0]          r_bar;
    logic [AW-1:0]       r_addr;
    logic                r_in_range;
    logic [31:0]         r_mag;
    sblt_pkg::t_row      r_row;
    logic [BAR_COUNT-1:0] r_valid;
    logic [23:0]         r_dsh;
    logic [31:0]         r_rem;
    logic [39:0]         r_acc;
    logic [31:0]         r_x;
    logic [4:0]          r_lp;
    logic [15:0]         r_frac;
    logic [15:0]         r_norm;
    logic [39:0]         r_sq_v;
    logic [23:0]         r_sq_rem;
    logic [19:0]         r_sq_root;
    logic                r_sq_second;
    logic [19:0]         r_s;
    logic [21:0]         r_p;
    logic [15:0]         r_sg;
    logic [15:0]         r_pfg;
    logic [15:0]         r_md;
    logic                r_ov;
    logic [5:0]          r_o_bar;
    logic [15:0]         r_o_level;
    logic [15:0]         r_o_peak;
    logic [15:0]         r_o_target;

    logic [RW-1:0]       ram_rdata;
    logic                ram_rd_en;
    logic                ram_wr_en;
    logic                out_free;
    sblt_pkg::t_row      ld_row;
    logic [31:0]         ld_mx;
    logic                ld_sat;
    logic [32:0]         div_t;
    logic                div_ge;
    logic [32:0]         div_sub;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         prod;
    logic [41:0]         avg_sum;
    logic [23:0]         avg_new;
    logic [4:0]          lead_pos;
    logic [20:0]         log_d;
    logic [41:0]         drop_sum;
    logic [17:0]         drop;
    logic [15:0]         norm_val;
    logic [23:0]         sq_rem2;
    logic [23:0]         sq_trial;
    logic                sq_ge;
    logic [23:0]         sq_rem_n;
    logic [19:0]         sq_root_n;
    logic [38:0]         t_sum;
    logic [15:0]         tg_val;
    logic [29:0]         sp_sum;
    logic                jump;
    logic [31:0]         mx_max;
    logic [31:0]         mx_dec;
    logic                t_up;
    logic [15:0]         t_diff;
    logic [32:0]         st_sum;
    logic [16:0]         lv_n;
    logic [15:0]         lv_sat;
    logic                hold;
    logic [32:0]         pf_sum;
    logic [16:0]         pstep;
    logic [15:0]         pk1;
    logic [15:0]         pk2;
    sblt_pkg::t_row      wr_row;

    assign i_cfg.ready   = 1'b1;
    assign o_out.valid   = r_ov;
    assign o_out.bar_out = r_o_bar;
    assign o_out.level   = r_o_level;
    assign o_out.peak    = r_o_peak;
    assign o_out.target  = r_o_target;

    assign out_free  = !r_ov || o_out.ready;
    assign o_pop     = (r_state == S_IDLE) && i_item_valid;
    assign ram_rd_en = o_pop && i_item.in_range;
    assign ram_wr_en = (r_state == S_WB) && out_free && r_in_range;
    assign wr_row    = r_row;

    sblt_ram #(
        .WIDTH (RW),
        .DEPTH (BAR_COUNT)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_row),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (i_item.bar[AW-1:0]),
        .o_rd_data (ram_rdata)
    );

    // load and divide
    always_comb begin
        ld_row      = r_valid[r_addr] ? sblt_pkg::t_row'(ram_rdata) : sblt_pkg::ROW_RESET;
        ld_mx       = (ld_row.rmax == 32'd0) ? 32'd1 : ld_row.rmax;
        ld_row.rmax = ld_mx;
        ld_sat      = ({8'd0, r_mag} >= {ld_mx, 8'd0});
        div_t       = {r_rem, r_dsh[23]};
        div_ge      = (div_t >= {1'b0, r_row.rmax});
        div_sub     = div_t - {1'b0, r_row.rmax};
    end

    // leading one of the magnitude
    always_comb begin
        lead_pos = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (r_mag[i]) begin
                lead_pos = 5'(i);
            end
        end
    end

    // shared multiplier
    always_comb begin
        mx_max = (r_mag > r_row.rmax) ? r_mag : r_row.rmax;
        t_up   = (r_row.target >= r_row.level);
        t_diff = t_up ? (r_row.target - r_row.level) : (r_row.level - r_row.target);
        log_d  = 21'h100000 - {1'b0, r_lp[3:0], r_frac};
        case (r_state)
            S_AVG1:  begin mul_a = 32'(sblt_pkg::AVG_NEW);     mul_b = {8'd0, r_dsh};        end
            S_AVG2:  begin mul_a = 32'(sblt_pkg::AVG_OLD);     mul_b = {8'd0, r_row.avg};    end
            S_LOG:   begin mul_a = r_x;                        mul_b = r_x;                  end
            S_NMUL:  begin mul_a = {11'd0, log_d};             mul_b = 32'(sblt_pkg::NORM_C24); end
            S_PMUL:  begin mul_a = {12'd0, r_s};               mul_b = {12'd0, r_sq_root};   end
            S_TMUL:  begin mul_a = {16'd0, r_norm};            mul_b = {10'd0, r_p};         end
            S_TGT:   begin mul_a = 32'(sblt_pkg::SPEED_SLOPE); mul_b = {16'd0, r_row.target}; end
            S_MAX:   begin mul_a = mx_max;                     mul_b = {16'd0, r_md};        end
            S_TMULT: begin mul_a = {16'd0, r_sg};              mul_b = {16'd0, t_diff};      end
            S_TPK:   begin mul_a = {16'd0, r_pfg};             mul_b = {16'd0, r_row.speed}; end
            default: begin mul_a = 32'd0;                      mul_b = 32'd0;                end
        endcase
        prod = {32'd0, mul_a} * {32'd0, mul_b};
    end

    // arithmetic on the product
    always_comb begin
        avg_sum  = {2'd0, r_acc} + {1'b0, prod[40:0]} + 42'd32768;
        avg_new  = (avg_sum[41:16] > {2'd0, sblt_pkg::RATIO_MAX}) ? sblt_pkg::RATIO_MAX
                                                                   : avg_sum[39:16];
        drop_sum = prod[41:0] + 42'h800000;
        drop     = drop_sum[41:24];
        if (drop >= 18'd65536) begin
            norm_val = 16'd0;
        end else if (drop == 18'd0) begin
            norm_val = 16'hFFFF;
        end else begin
            norm_val = 16'(17'h10000 - drop[16:0]);
        end

        sq_rem2   = {r_sq_rem[21:0], r_sq_v[39:38]};
        sq_trial  = {2'd0, r_sq_root, 2'b01};
        sq_ge     = (sq_rem2 >= sq_trial);
        sq_rem_n  = sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
        sq_root_n = {r_sq_root[18:0], sq_ge};

        t_sum  = {1'b0, prod[37:0]} + 39'd32768;
        tg_val = (t_sum[38:32] != 7'd0) ? 16'hFFFF : t_sum[31:16];
        sp_sum = {1'b0, prod[28:0]} + 30'd32768;
        jump   = ({1'b0, r_row.target} > ({1'b0, r_row.peak} + {1'b0, sblt_pkg::PEAK_JUMP}));
        mx_dec = (prod[47:16] == 32'd0) ? 32'd1 : prod[47:16];

        st_sum = {1'b0, prod[31:0]} + 33'd32768;
        lv_n   = t_up ? ({1'b0, r_row.level} + st_sum[32:16])
                      : ({1'b0, r_row.level} - st_sum[32:16]);
        lv_sat = lv_n[16] ? 16'hFFFF : lv_n[15:0];

        hold   = ({1'b0, r_row.peak} > ({1'b0, r_row.level} + {1'b0, sblt_pkg::PEAK_HOLD}));
        pf_sum = {1'b0, prod[31:0]} + 33'd32768;
        pstep  = pf_sum[32:16];
        if (hold) begin
            pk1 = (pstep >= {1'b0, r_row.peak}) ? 16'd0 : (r_row.peak - pstep[15:0]);
        end else begin
            pk1 = r_row.peak;
        end
        pk2 = (pk1 < r_row.level) ? r_row.level : pk1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_ov       <= 1'b0;
            r_sg       <= sblt_pkg::SMOOTH_GAIN_RST;
            r_pfg      <= sblt_pkg::PEAK_FALL_GAIN_RST;
            r_md       <= sblt_pkg::MAX_DECAY_RST;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    sblt_pkg::CFG_SMOOTH_GAIN:    r_sg  <= i_cfg.data;
                    sblt_pkg::CFG_PEAK_FALL_GAIN: r_pfg <= i_cfg.data;
                    sblt_pkg::CFG_MAX_DECAY:      r_md  <= i_cfg.data;
                    default: ;
                endcase
            end
            if (r_ov && o_out.ready && (r_state != S_WB)) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_cmd      <= i_item.cmd;
                        r_bar      <= i_item.bar;
                        r_addr     <= i_item.bar[AW-1:0];
                        r_mag      <= i_item.mag;
                        r_in_range <= i_item.in_range;
                        r_state    <= i_item.in_range ? S_LOAD : S_WB;
                    end
                end
                S_LOAD: begin
                    r_row <= ld_row;
                    if (r_cmd) begin
                        r_state <= S_TMULT;
                    end else if (ld_sat) begin
                        r_dsh   <= sblt_pkg::RATIO_MAX;
                        r_state <= S_AVG1;
                    end else begin
                        r_rem   <= {8'd0, r_mag[31:8]};
                        r_dsh   <= {r_mag[7:0], 16'd0};
                        r_cnt   <= 5'd23;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? div_sub[31:0] : div_t[31:0];
                    r_dsh <= {r_dsh[22:0], div_ge};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= S_AVG1;
                    end
                end
                S_AVG1: begin
                    r_acc   <= prod[39:0];
                    r_state <= S_AVG2;
                end
                S_AVG2: begin
                    r_row.avg <= avg_new;
                    r_state   <= S_LOGN;
                end
                S_LOGN: begin
                    r_sq_v      <= {r_row.avg, 16'd0};
                    r_sq_rem    <= 24'd0;
                    r_sq_root   <= 20'd0;
                    r_sq_second <= 1'b0;
                    if (r_mag == 32'd0) begin
                        r_norm  <= 16'd0;
                        r_cnt   <= 5'd19;
                        r_state <= S_SQRT;
                    end else if (lead_pos >= 5'd16) begin
                        r_norm  <= 16'hFFFF;
                        r_cnt   <= 5'd19;
                        r_state <= S_SQRT;
                    end else begin
                        r_x     <= r_mag << (5'd31 - lead_pos);
                        r_lp    <= lead_pos;
                        r_frac  <= 16'd0;
                        r_cnt   <= 5'd15;
                        r_state <= S_LOG;
                    end
                end
                S_LOG: begin
                    r_x    <= prod[63] ? prod[63:32] : prod[62:31];
                    r_frac <= {r_frac[14:0], prod[63]};
                    r_cnt  <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= S_NMUL;
                    end
                end
                S_NMUL: begin
                    r_norm  <= norm_val;
                    r_cnt   <= 5'd19;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if ((r_cnt == 5'd0) && !r_sq_second) begin
                        r_s         <= sq_root_n;
                        r_sq_v      <= {4'd0, sq_root_n, 16'd0};
                        r_sq_rem    <= 24'd0;
                        r_sq_root   <= 20'd0;
                        r_sq_second <= 1'b1;
                        r_cnt       <= 5'd19;
                    end else begin
                        r_sq_v    <= {r_sq_v[37:0], 2'b00};
                        r_sq_rem  <= sq_rem_n;
                        r_sq_root <= sq_root_n;
                        r_cnt     <= r_cnt - 5'd1;
                        if (r_cnt == 5'd0) begin
                            r_state <= S_PMUL;
                        end
                    end
                end
                S_PMUL: begin
                    r_p     <= prod[37:16];
                    r_state <= S_TMUL;
                end
                S_TMUL: begin
                    r_row.target <= tg_val;
                    r_state      <= S_TGT;
                end
                S_TGT: begin
                    if (jump) begin
                        r_row.peak  <= r_row.target;
                        r_row.speed <= sblt_pkg::SPEED_BASE + {2'd0, sp_sum[29:16]};
                    end
                    r_state <= S_MAX;
                end
                S_MAX: begin
                    r_row.rmax <= mx_dec;
                    r_state    <= S_WB;
                end
                S_TMULT: begin
                    r_row.level <= lv_sat;
                    r_state     <= S_TPK;
                end
                S_TPK: begin
                    r_row.peak <= pk2;
                    r_state    <= S_WB;
                end
                S_WB: begin
                    if (out_free) begin
                        if (r_in_range) begin
                            r_valid[r_addr] <= 1'b1;
                        end
                        r_ov       <= 1'b1;
                        r_o_bar    <= r_bar;
                        r_o_level  <= r_in_range ? r_row.level  : 16'd0;
                        r_o_peak   <= r_in_range ? r_row.peak   : 16'd0;
                        r_o_target <= r_in_range ? r_row.target : 16'd0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SBLT_ASSERT_IMPL(a_rmax_nonzero, i_clk, i_rst_n, ram_wr_en, wr_row.rmax != 32'd0, "running max stored as zero")
    `SBLT_ASSERT(a_div_done, i_clk, i_rst_n, (r_state == S_DIV && r_cnt == 5'd0) |=> r_state == S_AVG1, "divider did not finish")
    `SBLT_ASSERT(a_out_from_wb, i_clk, i_rst_n, $rose(r_ov) |-> $past(r_state == S_WB), "result raised outside writeback")

endmodule
